// ----- rtl/dpf_pkg.sv -----
// Shared types and constants for the derivative peak finder.
// Used by dpf_csr_regs, dpf_judge and derivative_peak_finder_unit; no dependencies.

package dpf_pkg;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RECORD_LENGTH    = 3'd0,
      REG_HEIGHT_THRESHOLD = 3'd1,
      REG_STEP_THRESHOLD   = 3'd2,
      REG_SLOPE_THRESHOLD  = 3'd3,
      REG_MAX_PEAKS        = 3'd4
   } dpf_reg_type;

   // Field widths fixed by the interface
   localparam int LENGTH_W    = 13;
   localparam int THRESHOLD_W = 15;
   localparam int COUNT_W     = 8;
   localparam int POSITION_W  = 12;
   localparam int INDEX_W     = 13;

   // Record limits
   localparam logic [LENGTH_W-1:0] MAX_SAMPLES = 13'd4096;
   localparam logic [INDEX_W:0]    EDGE_GUARD  = 14'd64;
   localparam logic [INDEX_W-1:0]  INDEX_MAX   = 13'd8191;

   // Reset values of the registers
   localparam logic [LENGTH_W-1:0]    RESET_RECORD_LENGTH    = 13'd1024;
   localparam logic [THRESHOLD_W-1:0] RESET_HEIGHT_THRESHOLD = 15'd256;
   localparam logic [THRESHOLD_W-1:0] RESET_STEP_THRESHOLD   = 15'd64;
   localparam logic [THRESHOLD_W-1:0] RESET_SLOPE_THRESHOLD  = 15'd45;
   localparam logic [COUNT_W-1:0]     RESET_MAX_PEAKS        = 8'd200;

   // Result kinds
   localparam logic KIND_PEAK  = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   typedef struct packed {
      logic [LENGTH_W-1:0]    record_length;
      logic [THRESHOLD_W-1:0] height_threshold;
      logic [THRESHOLD_W-1:0] step_threshold;
      logic [THRESHOLD_W-1:0] slope_threshold;
      logic [COUNT_W-1:0]     max_peaks;
   } dpf_cfg_type;

   typedef struct packed {
      logic                  emit;
      logic                  kind;
      logic [POSITION_W-1:0] position;
      logic [COUNT_W-1:0]    total;
   } dpf_result_type;

endpackage

// ----- rtl/dpf_csr_regs.sv -----
// Configuration registers of the derivative peak finder.
// Depends on dpf_pkg for register indexes, widths and reset values.

module dpf_csr_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [dpf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dpf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output dpf_pkg::dpf_cfg_type            cfg
);
   import dpf_pkg::*;

   dpf_cfg_type cfg_ff;
   dpf_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_RECORD_LENGTH:    cfg_in.record_length    = csr_wdata[LENGTH_W-1:0];
            REG_HEIGHT_THRESHOLD: cfg_in.height_threshold = csr_wdata[THRESHOLD_W-1:0];
            REG_STEP_THRESHOLD:   cfg_in.step_threshold   = csr_wdata[THRESHOLD_W-1:0];
            REG_SLOPE_THRESHOLD:  cfg_in.slope_threshold  = csr_wdata[THRESHOLD_W-1:0];
            REG_MAX_PEAKS:        cfg_in.max_peaks        = csr_wdata[COUNT_W-1:0];
            default:              cfg_in = cfg_ff;  // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.record_length    <= RESET_RECORD_LENGTH;
         cfg_ff.height_threshold <= RESET_HEIGHT_THRESHOLD;
         cfg_ff.step_threshold   <= RESET_STEP_THRESHOLD;
         cfg_ff.slope_threshold  <= RESET_SLOPE_THRESHOLD;
         cfg_ff.max_peaks        <= RESET_MAX_PEAKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/dpf_judge.sv -----
// Sample window, record counters and peak qualification of the peak finder.
// Depends on dpf_pkg; state advances only when the top level moves the staged word on.

module dpf_judge #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dpf_pkg::dpf_cfg_type          cfg,
   input  logic                          stage_valid,
   input  logic                          advance,
   input  logic signed [SAMPLE_BITS-1:0] stage_amplitude,
   input  logic signed [SAMPLE_BITS-1:0] stage_first_derivative,
   input  logic signed [SAMPLE_BITS-1:0] stage_second_derivative,
   input  logic                          stage_end_of_record,
   output dpf_pkg::dpf_result_type       result,
   output logic signed [SAMPLE_BITS-1:0] result_height
);
   import dpf_pkg::*;

   localparam int CMP_W = ((SAMPLE_BITS > THRESHOLD_W) ? SAMPLE_BITS : THRESHOLD_W) + 2;
   localparam int SEXT_W = CMP_W - SAMPLE_BITS;
   localparam int ZEXT_W = CMP_W - THRESHOLD_W;

   logic signed [SAMPLE_BITS-1:0] amp_win_ff [2];
   logic signed [SAMPLE_BITS-1:0] slope_win_ff [2];
   logic signed [SAMPLE_BITS-1:0] curv_ff;
   logic [INDEX_W-1:0]            index_ff;
   logic [INDEX_W-1:0]            index_in;
   logic [COUNT_W-1:0]            peaks_ff;
   logic [COUNT_W-1:0]            peaks_in;

   logic [LENGTH_W-1:0]   len_cap;
   logic [INDEX_W-1:0]    pos;
   logic                  in_range;
   logic                  below_max;
   logic                  judged;
   logic                  qualifies;
   logic signed [CMP_W-1:0] a_prev, a_cur, a_new, f_prev, f_cur, f_new;
   logic signed [CMP_W-1:0] hth, sth, lth, lth_neg;
   logic                  c_height, c_slope, c_step, c_turn;

   always_comb begin
      len_cap   = (cfg.record_length > MAX_SAMPLES) ? MAX_SAMPLES : cfg.record_length;
      pos       = index_ff - INDEX_W'(2);
      in_range  = (index_ff > INDEX_W'(1)) &&
                  (({1'b0, pos} + EDGE_GUARD) < {1'b0, len_cap});
      below_max = peaks_ff < cfg.max_peaks;

      a_prev = $signed({{SEXT_W{amp_win_ff[0][SAMPLE_BITS-1]}}, amp_win_ff[0]});
      a_cur  = $signed({{SEXT_W{amp_win_ff[1][SAMPLE_BITS-1]}}, amp_win_ff[1]});
      a_new  = $signed({{SEXT_W{stage_amplitude[SAMPLE_BITS-1]}}, stage_amplitude});
      f_prev = $signed({{SEXT_W{slope_win_ff[0][SAMPLE_BITS-1]}}, slope_win_ff[0]});
      f_cur  = $signed({{SEXT_W{slope_win_ff[1][SAMPLE_BITS-1]}}, slope_win_ff[1]});
      f_new  = $signed({{SEXT_W{stage_first_derivative[SAMPLE_BITS-1]}},
                        stage_first_derivative});
      hth     = $signed({{ZEXT_W{1'b0}}, cfg.height_threshold});
      sth     = $signed({{ZEXT_W{1'b0}}, cfg.step_threshold});
      lth     = $signed({{ZEXT_W{1'b0}}, cfg.slope_threshold});
      lth_neg = -lth;

      c_height = a_cur > hth;
      c_slope  = (f_cur <<< 1) < lth;
      c_step   = ((a_cur - a_prev) > sth) || ((a_new - a_cur) < sth);
      c_turn   = (f_prev > lth) || (f_new < lth_neg);
      qualifies = c_height && c_slope && curv_ff[SAMPLE_BITS-1] && c_step && c_turn;

      judged = !stage_end_of_record && in_range && below_max && qualifies;

      result.emit     = stage_valid && (stage_end_of_record || judged);
      result.kind     = stage_end_of_record ? KIND_COUNT : KIND_PEAK;
      result.position = stage_end_of_record ? '0 : pos[POSITION_W-1:0];
      result.total    = stage_end_of_record ? peaks_ff : peaks_ff + COUNT_W'(1);
      result_height   = stage_end_of_record ? '0 : amp_win_ff[1];

      // the flagged word closes the record; otherwise count up and saturate
      if (stage_end_of_record) begin
         index_in = '0;
         peaks_in = '0;
      end else begin
         index_in = (index_ff != INDEX_MAX) ? index_ff + INDEX_W'(1) : index_ff;
         peaks_in = judged ? peaks_ff + COUNT_W'(1) : peaks_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         peaks_ff <= '0;
      end else if (advance) begin
         index_ff <= index_in;
         peaks_ff <= peaks_in;
      end
   end

   // window payload: only read once two samples of the record have passed
   always_ff @(posedge clock) begin
      if (advance) begin
         amp_win_ff[0]   <= amp_win_ff[1];
         amp_win_ff[1]   <= stage_amplitude;
         slope_win_ff[0] <= slope_win_ff[1];
         slope_win_ff[1] <= stage_first_derivative;
         curv_ff         <= stage_second_derivative;
      end
   end

endmodule

// ----- rtl/derivative_peak_finder_unit.sv -----
// Top level of the derivative peak finder: input stage, result register and assertions.
// Depends on dpf_pkg, dpf_csr_regs and dpf_judge.
//
//   Channel  Direction  Handshake              Word
//   req_     in         req_valid / req_stall  amplitude, derivatives, end of record
//   rsp_     out        rsp_valid / rsp_stall  kind, position, height, total
//   csr_     in         csr_write_en           register index, data
//
// One word is accepted per cycle while req_stall is low; a result passes from its word's
// input register through the judging logic into the result register.
// Synchronous active-high reset clears the record counters and both valid flags.
// A held rsp_stall blocks the input stage only when it holds a word that yields
// a result; words yielding none keep flowing past a stalled result.

module derivative_peak_finder_unit #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample_amplitude,
   input  logic signed [SAMPLE_BITS-1:0]        req_first_derivative,
   input  logic signed [SAMPLE_BITS-1:0]        req_second_derivative,
   input  logic                                 req_end_of_record,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_result_kind,
   output logic [dpf_pkg::POSITION_W-1:0]       rsp_peak_position,
   output logic signed [SAMPLE_BITS-1:0]        rsp_peak_height,
   output logic [dpf_pkg::COUNT_W-1:0]          rsp_peak_total,
   input  logic                                 csr_write_en,
   input  logic [dpf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [dpf_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import dpf_pkg::*;

   dpf_cfg_type    cfg;
   dpf_result_type result;
   logic signed [SAMPLE_BITS-1:0] result_height;

   logic                          stage_valid_ff, stage_valid_in;
   logic signed [SAMPLE_BITS-1:0] stage_amp_ff, stage_fd_ff, stage_sd_ff;
   logic                          stage_eor_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_kind_ff;
   logic [POSITION_W-1:0]         rsp_pos_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_height_ff;
   logic [COUNT_W-1:0]            rsp_total_ff;
   logic                          out_free;
   logic                          advance;
   logic                          accept;

   dpf_csr_regs u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   dpf_judge #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_judge (
      .clock                   (clock),
      .reset                   (reset),
      .cfg                     (cfg),
      .stage_valid             (stage_valid_ff),
      .advance                 (advance),
      .stage_amplitude         (stage_amp_ff),
      .stage_first_derivative  (stage_fd_ff),
      .stage_second_derivative (stage_sd_ff),
      .stage_end_of_record     (stage_eor_ff),
      .result                  (result),
      .result_height           (result_height)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = stage_valid_ff && (out_free || !result.emit);
      req_stall = stage_valid_ff && !advance;
      accept    = req_valid && !req_stall;

      priority if (accept)  stage_valid_in = 1'b1;
      else if (advance)     stage_valid_in = 1'b0;
      else                  stage_valid_in = stage_valid_ff;

      // load a new result, else drop the old one once taken
      priority if (advance && result.emit) rsp_valid_in = 1'b1;
      else if (!rsp_stall)                 rsp_valid_in = 1'b0;
      else                                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_amp_ff <= req_sample_amplitude;
         stage_fd_ff  <= req_first_derivative;
         stage_sd_ff  <= req_second_derivative;
         stage_eor_ff <= req_end_of_record;
      end
      if (advance && result.emit) begin
         rsp_kind_ff   <= result.kind;
         rsp_pos_ff    <= result.position;
         rsp_height_ff <= result_height;
         rsp_total_ff  <= result.total;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_peak_position = rsp_pos_ff;
   assign rsp_peak_height   = rsp_height_ff;
   assign rsp_peak_total    = rsp_total_ff;

   // Stage is only stalled while it holds a word
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_valid_ff)
      else $error("input stalled with an empty stage");

   // Never overwrite a result that is still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && result.emit) |-> out_free)
      else $error("result register overwritten while stalled");

   // A stalled stage keeps its word
   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !advance) |=> (stage_valid_ff && $stable(stage_eor_ff)))
      else $error("staged word lost");

   // A peak result always counts itself
   a_peak_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_PEAK)) |-> (rsp_total_ff != '0))
      else $error("peak reported with zero total");

endmodule

// ----- tb/tb_derivative_peak_finder_unit.sv -----
// Self-checking testbench for derivative_peak_finder_unit: directed table, then random records.
// Predicts every peak and count word in-line and compares field by field at the result port.
// Depends on dpf_pkg and the RTL of the block only.

module tb_derivative_peak_finder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import dpf_pkg::*;

   localparam int SAMPLE_LIMIT  = 4096;
   localparam int EDGE_SAMPLES  = 64;
   localparam int INDEX_CEILING = 8191;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_WORDS   = 160;
   localparam logic [CSR_INDEX_W-1:0] FIRST_UNUSED_REG = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] LAST_UNUSED_REG  = 3'd7;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic signed [15:0] amplitude;
      logic signed [15:0] slope;
      logic signed [15:0] curvature;
      logic               last;
      bit                 count_known;
      logic [COUNT_W-1:0] count;
   } stim_row_type;

   typedef struct {
      logic                  kind;
      logic [POSITION_W-1:0] position;
      logic signed [15:0]    height;
      logic [COUNT_W-1:0]    total;
   } peak_report_type;

   typedef struct {
      logic [CSR_DATA_W-1:0] length;
      logic [CSR_DATA_W-1:0] height;
      logic [CSR_DATA_W-1:0] step;
      logic [CSR_DATA_W-1:0] slope;
      logic [CSR_DATA_W-1:0] max_peaks;
      idle_mode_type         mode;
   } phase_setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_sample_amplitude = '0;
   logic signed [15:0] req_first_derivative = '0;
   logic signed [15:0] req_second_derivative = '0;
   logic req_end_of_record = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_result_kind;
   logic [POSITION_W-1:0] rsp_peak_position;
   logic signed [15:0] rsp_peak_height;
   logic [COUNT_W-1:0] rsp_peak_total;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state and its copy of the registers
   logic signed [15:0] amp_hist [2] = '{16'sd0, 16'sd0};
   logic signed [15:0] slope_hist [2] = '{16'sd0, 16'sd0};
   logic signed [15:0] curv_held = 16'sd0;
   logic [INDEX_W-1:0] rec_index = '0;
   logic [COUNT_W-1:0] peaks_seen = '0;
   logic [LENGTH_W-1:0] cfg_length = RESET_RECORD_LENGTH;
   logic [THRESHOLD_W-1:0] cfg_height = RESET_HEIGHT_THRESHOLD;
   logic [THRESHOLD_W-1:0] cfg_step = RESET_STEP_THRESHOLD;
   logic [THRESHOLD_W-1:0] cfg_slope = RESET_SLOPE_THRESHOLD;
   logic [COUNT_W-1:0] cfg_max_peaks = RESET_MAX_PEAKS;

   peak_report_type awaited_reports [$];
   peak_report_type want_report;
   idle_mode_type idle_mode = IDLE_NONE;
   int failures = 0;
   int words_sent = 0;

   // Reset settings throughout; rows with a count typed in end a record
   stim_row_type directed_rows [15] = '{
      '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 8'd0},             // record ended on its lead-in
      '{16'sd50, 16'sd0, 16'sd0, 1'b0, 1'b0, 8'd0},
      '{16'sd100, 16'sd100, 16'sd0, 1'b0, 1'b0, 8'd0},
      '{16'sd1000, 16'sd0, -16'sd5, 1'b0, 1'b0, 8'd0},
      '{16'sd200, -16'sd100, 16'sd0, 1'b0, 1'b0, 8'd0},
      '{16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0, 1'b0, 8'd0},
      '{16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 8'd0},
      '{16'sd0, 16'sh7FFF, 16'sd0, 1'b0, 1'b0, 8'd0},
      '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 8'd2},
      '{16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 8'd0},
      '{16'sd0, 16'sd46, 16'sd0, 1'b0, 1'b0, 8'd0},
      '{16'sd256, 16'sd22, -16'sd1, 1'b0, 1'b0, 8'd0},          // height equal to threshold
      '{16'sd257, 16'sd22, -16'sd1, 1'b0, 1'b0, 8'd0},
      '{16'sd100, -16'sd46, 16'sd0, 1'b0, 1'b0, 8'd0},
      '{16'sd100, 16'sd0, 16'sd0, 1'b1, 1'b1, 8'd1}
   };

   phase_setting_type phase_settings [9] = '{
      '{15'd70, 15'd200, 15'd40, 15'd30, 15'd255, IDLE_NONE},
      '{15'd1024, 15'd300, 15'd64, 15'd45, 15'h7FFF, IDLE_SENDER},
      '{15'd0, 15'd0, 15'd0, 15'd0, 15'd200, IDLE_RECEIVER},
      '{15'd65, 15'd10, 15'd5, 15'd3, 15'd1, IDLE_BOTH},
      '{15'd4096, 15'd500, 15'd60, 15'd40, 15'h7F03, IDLE_NONE},
      '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'd255, IDLE_SENDER},
      '{15'd90, 15'd150, 15'd20, 15'd25, 15'd0, IDLE_RECEIVER},
      '{15'd2000, 15'd100, 15'd100, 15'd10, 15'd255, IDLE_BOTH},
      '{15'd4096, 15'd50, 15'd10, 15'd10, 15'd255, IDLE_NONE}
   };

   derivative_peak_finder_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sample_amplitude  (req_sample_amplitude),
      .req_first_derivative  (req_first_derivative),
      .req_second_derivative (req_second_derivative),
      .req_end_of_record     (req_end_of_record),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_peak_position     (rsp_peak_position),
      .rsp_peak_height       (rsp_peak_height),
      .rsp_peak_total        (rsp_peak_total),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int idle_percent(input bit receiver_side);
      case (idle_mode)
         IDLE_SENDER:   return receiver_side ? 0 : 71;
         IDLE_RECEIVER: return receiver_side ? 71 : 0;
         IDLE_BOTH:     return 27;
         default:       return 0;
      endcase
   endfunction

   function automatic logic signed [15:0] sat16(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] index,
                                     input logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_RECORD_LENGTH:    cfg_length = data[LENGTH_W-1:0];
         REG_HEIGHT_THRESHOLD: cfg_height = data[THRESHOLD_W-1:0];
         REG_STEP_THRESHOLD:   cfg_step = data[THRESHOLD_W-1:0];
         REG_SLOPE_THRESHOLD:  cfg_slope = data[THRESHOLD_W-1:0];
         REG_MAX_PEAKS:        cfg_max_peaks = data[COUNT_W-1:0];
         default: ;
      endcase
   endfunction

   // Judge the held sample against its neighbours, then advance the windows
   function automatic void judge_word(input stim_row_type w, output bit produced,
                                      output peak_report_type r);
      int pos, eff_len, a_prev, a_cur, a_new, f_prev, f_cur, f_new, curv;
      int hth, sth, lth;
      produced = 1'b0;
      r = '{default: '0};
      a_prev = amp_hist[0];
      a_cur = amp_hist[1];
      a_new = w.amplitude;
      f_prev = slope_hist[0];
      f_cur = slope_hist[1];
      f_new = w.slope;
      curv = curv_held;
      hth = cfg_height;
      sth = cfg_step;
      lth = cfg_slope;
      eff_len = (cfg_length > SAMPLE_LIMIT) ? SAMPLE_LIMIT : int'(cfg_length);
      pos = int'(rec_index) - 2;
      if (w.last) begin
         produced = 1'b1;
         r.kind = KIND_COUNT;
         r.total = peaks_seen;
      end else if (rec_index >= 2 && pos + EDGE_SAMPLES < eff_len
                   && peaks_seen < cfg_max_peaks) begin
         if (a_cur > hth && 2 * f_cur < lth && curv < 0
             && (a_cur - a_prev > sth || a_new - a_cur < sth)
             && (f_prev > lth || f_new < -lth)) begin
            peaks_seen = peaks_seen + 8'd1;
            produced = 1'b1;
            r.kind = KIND_PEAK;
            r.position = pos[POSITION_W-1:0];
            r.height = a_cur[15:0];
            r.total = peaks_seen;
         end
      end
      amp_hist[0] = amp_hist[1];
      amp_hist[1] = w.amplitude;
      slope_hist[0] = slope_hist[1];
      slope_hist[1] = w.slope;
      curv_held = w.curvature;
      if (w.last) begin
         rec_index = '0;
         peaks_seen = '0;
      end else if (rec_index < INDEX_CEILING) begin
         rec_index = rec_index + INDEX_W'(1);
      end
   endfunction

   // Mostly values near the thresholds, so that peaks turn up; now and then any value
   function automatic stim_row_type make_sample(input logic last);
      stim_row_type s;
      int hth, lth;
      hth = cfg_height;
      lth = cfg_slope;
      s.last = last;
      s.count_known = 1'b0;
      s.count = '0;
      if ($urandom_range(0, 9) == 0) begin
         s.amplitude = 16'($urandom);
         s.slope = 16'($urandom);
         s.curvature = 16'($urandom);
      end else begin
         s.amplitude = sat16(int'($urandom_range(0, 4 * hth + 64)) - hth);
         s.slope = sat16(int'($urandom_range(0, 6 * lth + 4)) - 3 * lth - 2);
         s.curvature = sat16(int'($urandom_range(0, 200)) - 120);
      end
      return s;
   endfunction

   task automatic send_word(input stim_row_type w);
      bit produced;
      peak_report_type r;
      while ($urandom_range(0, 99) < idle_percent(1'b0)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_amplitude <= w.amplitude;
      req_first_derivative <= w.slope;
      req_second_derivative <= w.curvature;
      req_end_of_record <= w.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      judge_word(w, produced, r);
      if (w.count_known) begin
         produced = 1'b1;
         r = '{KIND_COUNT, '0, '0, w.count};
      end
      if (produced) awaited_reports.push_back(r);
      words_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_reports.size() != 0) @(posedge clock);
      // words yielding nothing may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      apply_reg(index, data);
   endtask

   task automatic send_record(input int samples, input bit end_on_lead_in);
      send_word(make_sample(end_on_lead_in));
      if (!end_on_lead_in) begin
         repeat (samples) send_word(make_sample(1'b0));
         send_word(make_sample(1'b1));
      end
   endtask

   function automatic void compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_stall <= $urandom_range(0, 99) < idle_percent(1'b1);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_reports.size() == 0) begin
            $display("%0t: word with nothing awaited: kind %0d position %0d height %0d total %0d",
                     $time, rsp_result_kind, rsp_peak_position, rsp_peak_height,
                     rsp_peak_total);
            failures++;
         end else begin
            want_report = awaited_reports.pop_front();
            compare_field("result_kind", want_report.kind, rsp_result_kind);
            compare_field("peak_position", want_report.position, rsp_peak_position);
            compare_field("peak_height", want_report.height, rsp_peak_height);
            compare_field("peak_total", want_report.total, rsp_peak_total);
         end
      end
   end

   initial begin
      int base, pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) send_word(directed_rows[i]);
      foreach (phase_settings[p]) begin
         settle();
         write_reg(REG_RECORD_LENGTH, phase_settings[p].length);
         write_reg(REG_HEIGHT_THRESHOLD, phase_settings[p].height);
         write_reg(REG_STEP_THRESHOLD, phase_settings[p].step);
         write_reg(REG_SLOPE_THRESHOLD, phase_settings[p].slope);
         write_reg(REG_MAX_PEAKS, phase_settings[p].max_peaks);
         // unused index: must leave every register alone
         write_reg(CSR_INDEX_W'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)),
                   CSR_DATA_W'($urandom));
         csr_write_en <= 1'b0;
         idle_mode = phase_settings[p].mode;
         words_sent = 0;
         // straddle the judging limit where the record length is short
         base = (cfg_length >= 65 && cfg_length <= 200) ? int'(cfg_length) - 64 : 0;
         while (words_sent < PHASE_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) send_record(0, 1'b1);
            else if (pick == 1) send_record($urandom_range(0, 3), 1'b0);
            else send_record(base + $urandom_range(0, 40), 1'b0);
         end
      end
      settle();
      if (failures == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/dpf_pkg.sv
rtl/dpf_csr_regs.sv
rtl/dpf_judge.sv
rtl/derivative_peak_finder_unit.sv
tb/tb_derivative_peak_finder_unit.sv
